// ----- rtl/core/complex_mixer_decimator_core_assert.svh -----
// Assertion macros for the complex mixer / decimator core.
// Used by the port checker; expects clk_i and rst_ni in scope.
`ifndef COMPLEX_MIXER_DECIMATOR_CORE_ASSERT_SVH
`define COMPLEX_MIXER_DECIMATOR_CORE_ASSERT_SVH

// Same-cycle implication, checked out of reset only.
`define CMD_ASSERT_NOW(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("complex_mixer_decimator_core: assertion failed");

// Next-cycle implication, checked out of reset only.
`define CMD_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("complex_mixer_decimator_core: assertion failed");

`endif

// ----- rtl/core/cmd_pkg.sv -----
// Shared types, constants and oscillator table for the complex mixer / decimator.
// No dependencies.
package cmd_pkg;

  localparam int SAMPLE_BITS     = 16;
  localparam int PHASE_BITS      = 32;
  localparam int TABLE_ADDR_BITS = 10;
  localparam int MAX_DECIMATION  = 1024;

  localparam int LO_FRAC   = 15;
  localparam int LO_W      = LO_FRAC + 1;
  localparam int DEC_W     = 11;
  localparam int CNT_W     = 10;
  localparam int PROD_W    = 2 * SAMPLE_BITS;
  localparam int SUM_W     = 42;
  localparam int DIVD_W    = SUM_W - LO_FRAC;
  localparam int STEP_W    = $clog2(DIVD_W);
  localparam int QIDX_W    = TABLE_ADDR_BITS - 2;
  localparam int QUARTER   = 2 ** QIDX_W;
  localparam int CFG_IDX_W = 2;
  localparam int CFG_DAT_W = 32;
  localparam int FIFO_DEPTH = 4;
  localparam int FIFO_PTR_W = $clog2(FIFO_DEPTH);

  typedef logic [CFG_IDX_W-1:0] cfg_idx_t;
  localparam cfg_idx_t CFG_PHASE_STEP = cfg_idx_t'(0);
  localparam cfg_idx_t CFG_DECIMATION = cfg_idx_t'(1);

  // Queue word from front to back
  typedef struct packed {
    logic signed [SAMPLE_BITS-1:0] si;
    logic signed [SAMPLE_BITS-1:0] sq;
    logic signed [LO_W-1:0]        lo_sin;
    logic signed [LO_W-1:0]        lo_cos;
    logic                          last;
    logic [DEC_W-1:0]              dec;
  } q_word_t;

  // Division request from back to divider
  typedef struct packed {
    logic                    valid;
    logic signed [SUM_W-1:0] sum_i;
    logic signed [SUM_W-1:0] sum_q;
    logic [DEC_W-1:0]        dec;
  } div_req_t;

  typedef enum logic [1:0] {
    DIV_IDLE,
    DIV_RUN,
    DIV_DONE
  } div_state_e;

  // Quarter-wave sine polynomial, Q30 coefficients
  localparam longint unsigned C1 = 64'd1686629713;
  localparam longint unsigned C3 = 64'd693598668;
  localparam longint unsigned C5 = 64'd85569306;
  localparam longint unsigned C7 = 64'd5026993;
  localparam longint unsigned C9 = 64'd172273;

  typedef logic [QUARTER-1:0][LO_FRAC-1:0] qsin_tab_t;

  function automatic logic [LO_FRAC-1:0] qsine_calc(input int unsigned k);
    longint unsigned x;
    longint unsigned x2;
    longint unsigned p;
    longint unsigned s;
    x  = longint'(k) << (30 - QIDX_W);
    x2 = (x * x) >> 30;
    p  = C9;
    p  = C7 - ((x2 * p) >> 30);
    p  = C5 - ((x2 * p) >> 30);
    p  = C3 - ((x2 * p) >> 30);
    p  = C1 - ((x2 * p) >> 30);
    s  = (x * p) >> 30;
    s  = (s + (64'd1 << (30 - LO_FRAC - 1))) >> (30 - LO_FRAC);
    if (s > 64'd32767) begin
      s = 64'd32767;
    end
    return s[LO_FRAC-1:0];
  endfunction

  function automatic qsin_tab_t qsin_build();
    qsin_tab_t t;
    for (int unsigned k = 0; k < QUARTER; k++) begin
      t[k] = qsine_calc(k);
    end
    return t;
  endfunction

  localparam qsin_tab_t           QSIN_TAB  = qsin_build();
  localparam logic [LO_FRAC-1:0]  QSIN_PEAK = qsine_calc(QUARTER);

  // Full-circle sine from the quarter table: mirror odd quadrants, negate quadrants two and three
  function automatic logic signed [LO_W-1:0] table_sine(input logic [TABLE_ADDR_BITS-1:0] addr);
    logic [1:0]           quad;
    logic [QIDX_W-1:0]    off;
    logic [QIDX_W:0]      k;
    logic [LO_FRAC-1:0]   mag;
    logic signed [LO_W-1:0] v;
    quad = addr[TABLE_ADDR_BITS-1 -: 2];
    off  = addr[QIDX_W-1:0];
    k    = quad[0] ? ((QIDX_W+1)'(QUARTER) - {1'b0, off}) : {1'b0, off};
    mag  = k[QIDX_W] ? QSIN_PEAK : QSIN_TAB[k[QIDX_W-1:0]];
    v    = {1'b0, mag};
    return quad[1] ? -v : v;
  endfunction

endpackage

// ----- rtl/core/complex_mixer_decimator_core.sv -----
// Top level of the complex mixer / boxcar decimator.
// Depends on cmd_pkg, cmd_front, cmd_fifo, cmd_back and cmd_div.
//
// Digital down converter: each complex sample is multiplied by exp(+j*theta) from a
// 32-bit phase accumulator and a quarter-wave sine table (top 10 phase bits), the
// products are summed over groups of D samples (register 1, 0 reads as 1, above 1024
// reads as 1024), and each group gives one word: the sum divided by D*2^15, truncated
// toward zero and saturated to 16 bits. Register 0 is the phase step per sample.
// Write configuration only while the core is idle. Input words are taken one per
// cycle while the four-deep queue has room; the back end registers the four products and
// accumulates them into the group sums. Each group end occupies the shared shift-subtract
// divider from hand-over through its run to the result register, and the back end holds
// the next group end until the divider is free again.
module complex_mixer_decimator_core
  import cmd_pkg::*;
(
  input  logic                          clk_i,
  input  logic                          rst_ni,
  // Sample channel
  input  logic                          in_valid_i,
  output logic                          in_ready_o,
  input  logic signed [SAMPLE_BITS-1:0] sample_i_i,
  input  logic signed [SAMPLE_BITS-1:0] sample_q_i,
  // Result channel
  output logic                          out_valid_o,
  input  logic                          out_ready_i,
  output logic signed [SAMPLE_BITS-1:0] out_i_o,
  output logic signed [SAMPLE_BITS-1:0] out_q_o,
  // Configuration write channel
  input  logic                          cfg_valid_i,
  output logic                          cfg_ready_o,
  input  cfg_idx_t                      cfg_index_i,
  input  logic [CFG_DAT_W-1:0]          cfg_data_i
);

  logic [PHASE_BITS-1:0] phase_step_q;
  logic [DEC_W-1:0]      decimation_q;
  logic                  q_push, q_pop, q_full, q_empty;
  q_word_t               q_in_word, q_out_word;
  div_req_t              div_req;
  logic                  div_ready;

  // Configuration registers: always ready, unknown indexes are dropped
  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_step_q <= '0;
      decimation_q <= DEC_W'(1);
    end else if (cfg_valid_i) begin
      unique case (cfg_index_i)
        CFG_PHASE_STEP: phase_step_q <= cfg_data_i[PHASE_BITS-1:0];
        CFG_DECIMATION: decimation_q <= cfg_data_i[DEC_W-1:0];
        default: ;
      endcase
    end
  end

  // Front: oscillator lookup and group tagging at acceptance
  cmd_front u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid_i),
    .in_ready_o   (in_ready_o),
    .sample_i_i   (sample_i_i),
    .sample_q_i   (sample_q_i),
    .phase_step_i (phase_step_q),
    .decimation_i (decimation_q),
    .q_full_i     (q_full),
    .q_push_o     (q_push),
    .q_word_o     (q_in_word)
  );

  // Queue: lets the front keep taking samples while the back waits on the divider
  cmd_fifo u_fifo (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (q_push),
    .push_word_i (q_in_word),
    .full_o      (q_full),
    .pop_i       (q_pop),
    .pop_word_o  (q_out_word),
    .empty_o     (q_empty)
  );

  // Back: mix and accumulate, hand each finished group to the divider
  cmd_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .q_empty_i   (q_empty),
    .q_word_i    (q_out_word),
    .q_pop_o     (q_pop),
    .div_ready_i (div_ready),
    .div_req_o   (div_req)
  );

  // Divider and result register
  cmd_div u_div (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .req_i       (div_req),
    .ready_o     (div_ready),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_i_o     (out_i_o),
    .out_q_o     (out_q_o)
  );

endmodule

// ----- rtl/core/cmd_front.sv -----
// Front end: accepts samples, runs the oscillator and tags group ends.
// Depends on cmd_pkg.
module cmd_front
  import cmd_pkg::*;
(
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          in_valid_i,
  output logic                          in_ready_o,
  input  logic signed [SAMPLE_BITS-1:0] sample_i_i,
  input  logic signed [SAMPLE_BITS-1:0] sample_q_i,
  input  logic [PHASE_BITS-1:0]         phase_step_i,
  input  logic [DEC_W-1:0]              decimation_i,
  input  logic                          q_full_i,
  output logic                          q_push_o,
  output q_word_t                       q_word_o
);

  logic [PHASE_BITS-1:0]      phase_q, phase_d;
  logic [CNT_W-1:0]           cnt_q, cnt_d;
  logic [DEC_W-1:0]           dec_eff;
  logic [DEC_W-1:0]           cnt_inc;
  logic                       last;
  logic [TABLE_ADDR_BITS-1:0] addr;
  logic                       accept;

  assign in_ready_o = !q_full_i;
  assign accept     = in_valid_i && !q_full_i;

  always_comb begin
    if (decimation_i == '0) begin
      dec_eff = DEC_W'(1);
    end else if (decimation_i > DEC_W'(MAX_DECIMATION)) begin
      dec_eff = DEC_W'(MAX_DECIMATION);
    end else begin
      dec_eff = decimation_i;
    end
  end

  assign cnt_inc = {1'b0, cnt_q} + DEC_W'(1);
  assign last    = cnt_inc >= dec_eff;
  assign addr    = phase_q[PHASE_BITS-1 -: TABLE_ADDR_BITS];

  always_comb begin
    phase_d = phase_q;
    cnt_d   = cnt_q;
    if (accept) begin
      phase_d = phase_q + phase_step_i;
      cnt_d   = last ? '0 : cnt_inc[CNT_W-1:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= '0;
      cnt_q   <= '0;
    end else begin
      phase_q <= phase_d;
      cnt_q   <= cnt_d;
    end
  end

  assign q_push_o        = accept;
  assign q_word_o.si     = sample_i_i;
  assign q_word_o.sq     = sample_q_i;
  assign q_word_o.lo_sin = table_sine(addr);
  assign q_word_o.lo_cos = table_sine(addr + TABLE_ADDR_BITS'(QUARTER));
  assign q_word_o.last   = last;
  assign q_word_o.dec    = dec_eff;

endmodule

// ----- rtl/core/cmd_fifo.sv -----
// Short register queue between front and back.
// Depends on cmd_pkg.
module cmd_fifo
  import cmd_pkg::*;
(
  input  logic    clk_i,
  input  logic    rst_ni,
  input  logic    push_i,
  input  q_word_t push_word_i,
  output logic    full_o,
  input  logic    pop_i,
  output q_word_t pop_word_o,
  output logic    empty_o
);

  q_word_t               mem_q [FIFO_DEPTH];
  logic [FIFO_PTR_W-1:0] wr_ptr_q, rd_ptr_q;
  logic [FIFO_PTR_W:0]   count_q;

  assign full_o     = count_q == (FIFO_PTR_W+1)'(FIFO_DEPTH);
  assign empty_o    = count_q == '0;
  assign pop_word_o = mem_q[rd_ptr_q];

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= push_word_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      if (push_i) begin
        wr_ptr_q <= wr_ptr_q + FIFO_PTR_W'(1);
      end
      if (pop_i) begin
        rd_ptr_q <= rd_ptr_q + FIFO_PTR_W'(1);
      end
      if (push_i && !pop_i) begin
        count_q <= count_q + (FIFO_PTR_W+1)'(1);
      end else if (pop_i && !push_i) begin
        count_q <= count_q - (FIFO_PTR_W+1)'(1);
      end
    end
  end

endmodule

// ----- rtl/core/cmd_back.sv -----
// Back end: complex multiply, group accumulation and hand-off to the divider.
// Depends on cmd_pkg.
module cmd_back
  import cmd_pkg::*;
(
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     q_empty_i,
  input  q_word_t  q_word_i,
  output logic     q_pop_o,
  input  logic     div_ready_i,
  output div_req_t div_req_o
);

  logic                     a_valid_q;
  logic                     a_last_q;
  logic [DEC_W-1:0]         a_dec_q;
  logic signed [PROD_W-1:0] p_ic_q, p_qs_q, p_is_q, p_qc_q;
  logic signed [SUM_W-1:0]  sum_i_q, sum_q_q;
  logic signed [PROD_W:0]   delta_i, delta_q;
  logic signed [SUM_W-1:0]  next_i, next_q;
  logic                     a_advance;
  logic                     pop;

  // Hold a group-end word until the divider is free
  assign a_advance = a_valid_q && (!a_last_q || div_ready_i);
  assign pop       = !q_empty_i && (!a_valid_q || a_advance);
  assign q_pop_o   = pop;

  assign delta_i = (PROD_W+1)'(p_ic_q) - (PROD_W+1)'(p_qs_q);
  assign delta_q = (PROD_W+1)'(p_is_q) + (PROD_W+1)'(p_qc_q);
  assign next_i  = sum_i_q + {{(SUM_W-PROD_W-1){delta_i[PROD_W]}}, delta_i};
  assign next_q  = sum_q_q + {{(SUM_W-PROD_W-1){delta_q[PROD_W]}}, delta_q};

  assign div_req_o.valid = a_advance && a_last_q;
  assign div_req_o.sum_i = next_i;
  assign div_req_o.sum_q = next_q;
  assign div_req_o.dec   = a_dec_q;

  always_ff @(posedge clk_i) begin
    if (pop) begin
      p_ic_q   <= q_word_i.si * q_word_i.lo_cos;
      p_qs_q   <= q_word_i.sq * q_word_i.lo_sin;
      p_is_q   <= q_word_i.si * q_word_i.lo_sin;
      p_qc_q   <= q_word_i.sq * q_word_i.lo_cos;
      a_last_q <= q_word_i.last;
      a_dec_q  <= q_word_i.dec;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      a_valid_q <= 1'b0;
      sum_i_q   <= '0;
      sum_q_q   <= '0;
    end else begin
      if (pop) begin
        a_valid_q <= 1'b1;
      end else if (a_advance) begin
        a_valid_q <= 1'b0;
      end
      if (a_advance) begin
        sum_i_q <= a_last_q ? '0 : next_i;
        sum_q_q <= a_last_q ? '0 : next_q;
      end
    end
  end

endmodule

// ----- rtl/core/cmd_div.sv -----
// Shift-subtract divider for both lanes, saturation and result register.
// Depends on cmd_pkg.
module cmd_div
  import cmd_pkg::*;
(
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  div_req_t                      req_i,
  output logic                          ready_o,
  output logic                          out_valid_o,
  input  logic                          out_ready_i,
  output logic signed [SAMPLE_BITS-1:0] out_i_o,
  output logic signed [SAMPLE_BITS-1:0] out_q_o
);

  localparam int STEP_RES_W = DEC_W + DIVD_W;

  div_state_e        state_q, state_d;
  logic [STEP_W-1:0] step_q;
  logic [DEC_W-1:0]  dec_q;
  logic [DEC_W-1:0]  rem_i_q, rem_q_q;
  logic [DIVD_W-1:0] dq_i_q, dq_q_q;
  logic              neg_i_q, neg_q_q;
  logic [SUM_W-1:0]  mag_i, mag_q;
  logic [STEP_RES_W-1:0] res_i, res_q;
  logic              start;
  logic              last_step;

  // One restoring step: bring in the next dividend bit, subtract if it fits
  function automatic logic [STEP_RES_W-1:0] div_step(input logic [DEC_W-1:0]  rem,
                                                     input logic [DIVD_W-1:0] dq,
                                                     input logic [DEC_W-1:0]  dec);
    logic [DEC_W-1:0] trial;
    logic             fits;
    trial = {rem[DEC_W-2:0], dq[DIVD_W-1]};
    fits  = trial >= dec;
    return {fits ? (trial - dec) : trial, dq[DIVD_W-2:0], fits};
  endfunction

  function automatic logic signed [SAMPLE_BITS-1:0] saturate(input logic [DIVD_W-1:0] q,
                                                             input logic neg);
    logic [SAMPLE_BITS-1:0] low;
    low = q[SAMPLE_BITS-1:0];
    if (neg) begin
      if (q > DIVD_W'(2 ** (SAMPLE_BITS - 1))) begin
        return {1'b1, {(SAMPLE_BITS-1){1'b0}}};
      end
      return -low;
    end
    if (q > DIVD_W'(2 ** (SAMPLE_BITS - 1) - 1)) begin
      return {1'b0, {(SAMPLE_BITS-1){1'b1}}};
    end
    return low;
  endfunction

  assign start     = (state_q == DIV_IDLE) && req_i.valid;
  assign last_step = step_q == STEP_W'(DIVD_W - 1);

  always_comb begin
    state_d     = state_q;
    ready_o     = 1'b0;
    out_valid_o = 1'b0;
    unique case (state_q)
      DIV_IDLE: begin
        ready_o = 1'b1;
        if (req_i.valid) begin
          state_d = DIV_RUN;
        end
      end
      DIV_RUN: begin
        if (last_step) begin
          state_d = DIV_DONE;
        end
      end
      DIV_DONE: begin
        out_valid_o = 1'b1;
        if (out_ready_i) begin
          state_d = DIV_IDLE;
        end
      end
      default: state_d = DIV_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= DIV_IDLE;
      step_q  <= '0;
    end else begin
      state_q <= state_d;
      if (start) begin
        step_q <= '0;
      end else if (state_q == DIV_RUN) begin
        step_q <= step_q + STEP_W'(1);
      end
    end
  end

  // Drop the fraction bits first: truncation toward zero nests for positive divisors
  assign mag_i = req_i.sum_i[SUM_W-1] ? SUM_W'(-req_i.sum_i) : SUM_W'(req_i.sum_i);
  assign mag_q = req_i.sum_q[SUM_W-1] ? SUM_W'(-req_i.sum_q) : SUM_W'(req_i.sum_q);
  assign res_i = div_step(rem_i_q, dq_i_q, dec_q);
  assign res_q = div_step(rem_q_q, dq_q_q, dec_q);

  always_ff @(posedge clk_i) begin
    if (start) begin
      dec_q   <= req_i.dec;
      neg_i_q <= req_i.sum_i[SUM_W-1];
      neg_q_q <= req_i.sum_q[SUM_W-1];
      dq_i_q  <= mag_i[SUM_W-1:LO_FRAC];
      dq_q_q  <= mag_q[SUM_W-1:LO_FRAC];
      rem_i_q <= '0;
      rem_q_q <= '0;
    end else if (state_q == DIV_RUN) begin
      {rem_i_q, dq_i_q} <= res_i;
      {rem_q_q, dq_q_q} <= res_q;
    end
  end

  assign out_i_o = saturate(dq_i_q, neg_i_q);
  assign out_q_o = saturate(dq_q_q, neg_q_q);

endmodule

// ----- rtl/core/cmd_checker.sv -----
// Port-level checks for the complex mixer / decimator core, bound to the top level.
// Depends on cmd_pkg and complex_mixer_decimator_core_assert.svh.
`include "complex_mixer_decimator_core_assert.svh"

module cmd_checker
  import cmd_pkg::*;
(
  input logic                          clk_i,
  input logic                          rst_ni,
  input logic                          in_valid_i,
  input logic                          in_ready_o,
  input logic                          out_valid_o,
  input logic                          out_ready_i,
  input logic signed [SAMPLE_BITS-1:0] out_i_o,
  input logic signed [SAMPLE_BITS-1:0] out_q_o,
  input logic                          cfg_valid_i,
  input logic                          cfg_ready_o
);

  // Hold a stalled result word steady
  `CMD_ASSERT_NEXT(a_out_hold, out_valid_o && !out_ready_i, out_valid_o && $stable({out_i_o, out_q_o}))

  // The divider returns to idle after each result is taken, so results never come back to back
  `CMD_ASSERT_NEXT(a_out_gap, out_valid_o && out_ready_i, !out_valid_o)

  // The queue only fills through an accepted sample
  `CMD_ASSERT_NOW(a_full_by_push, $fell(in_ready_o), $past(in_valid_i && in_ready_o))

  // Configuration writes are never stalled
  `CMD_ASSERT_NOW(a_cfg_ready, cfg_valid_i, cfg_ready_o)

endmodule

bind complex_mixer_decimator_core cmd_checker u_cmd_checker (.*);
